// ===== rtl/fcm_pkg.sv =====
// fcm_pkg: shared widths, register indexes, reset values and types for the
// faded clip mixer. No dependencies.
package fcm_pkg;

  localparam int BUFFER_SAMPLES_DEF = 65536;
  localparam int MAX_CHANNELS_DEF   = 2;

  localparam int SAMPLE_W    = 16;
  localparam int FRAME_W     = 24;
  localparam int GAIN_W      = 16;
  localparam int DEST_W      = 16;
  localparam int CHCNT_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int RAMP_BITS   = 16;              // quotient bits of a ramp
  localparam int RAMP_W      = RAMP_BITS + 1;   // holds unity (1 << RAMP_BITS)
  localparam int Q_W         = 17;              // magnitude of the scaled sample
  localparam int SUM_W       = 19;              // entry +/- scaled sample
  localparam int ADDR_CALC_W = 28;              // (dest + frame) * channels + channel

  localparam int DIV_LAT = RAMP_BITS;           // one quotient bit per stage
  localparam int MUL_LAT = 3;                   // three registered multiplies

  localparam logic [RAMP_W-1:0] RAMP_UNITY = RAMP_W'(1) << RAMP_BITS;

  localparam logic [GAIN_W-1:0]  CLIP_GAIN_RST     = 16'd16384;
  localparam logic [CHCNT_W-1:0] CHANNEL_COUNT_RST = 2'd2;

  localparam logic REQ_MIX  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_GAIN     = 3'd0,
    REG_FADE_IN       = 3'd1,
    REG_FADE_OUT      = 3'd2,
    REG_CLIP_FRAMES   = 3'd3,
    REG_DEST_START    = 3'd4,
    REG_CHANNEL_COUNT = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } fcm_state_t;

  // control bits of an item at the buffer write stage
  typedef struct packed {
    logic valid;
    logic is_read;
    logic drop;
    logic neg;
  } item_ctl_t;

endpackage

// ===== rtl/fcm_ramp_div.sv =====
// fcm_ramp_div: pipelined restoring divider for one fade ramp,
// floor(num * 2^16 / den) for num < den, or unity when full is set. Uses fcm_pkg.
module fcm_ramp_div (
  input  logic                          clk,
  input  logic [fcm_pkg::FRAME_W-1:0]   num,
  input  logic [fcm_pkg::FRAME_W-1:0]   den,
  input  logic                          full,
  output logic [fcm_pkg::RAMP_W-1:0]    ramp
);

  localparam int STAGES = fcm_pkg::RAMP_BITS;
  localparam int NW     = fcm_pkg::FRAME_W;

  logic [NW-1:0]     rem    [1:STAGES-1];
  logic [STAGES-1:0] quo    [1:STAGES];
  logic              full_p [1:STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_step
    logic [NW-1:0]     r_in;
    logic [STAGES-1:0] q_in;
    logic              f_in;
    logic [NW:0]       dbl;
    logic [NW:0]       diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign r_in = num;
      assign q_in = '0;
      assign f_in = full;
    end else begin : g_next
      assign r_in = rem[i];
      assign q_in = quo[i];
      assign f_in = full_p[i];
    end

    assign dbl  = {r_in, 1'b0};
    assign ge   = dbl >= {1'b0, den};
    assign diff = dbl - {1'b0, den};

    always_ff @(posedge clk) begin
      quo[i+1]    <= {q_in[STAGES-2:0], ge};
      full_p[i+1] <= f_in;
    end

    if (i < STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[i+1] <= ge ? diff[NW-1:0] : dbl[NW-1:0];
      end
    end
  end

  assign ramp = full_p[STAGES] ? fcm_pkg::RAMP_UNITY : {1'b0, quo[STAGES]};

endmodule

// ===== rtl/fcm_gain_mul.sv =====
// fcm_gain_mul: three registered multiplies, gain by fade-in, by fade-out,
// then sample magnitude by effective gain. Uses fcm_pkg.
module fcm_gain_mul (
  input  logic                          clk,
  input  logic [fcm_pkg::GAIN_W-1:0]    clip_gain,
  input  logic [fcm_pkg::RAMP_W-1:0]    rin,
  input  logic [fcm_pkg::RAMP_W-1:0]    rout,
  input  logic [fcm_pkg::SAMPLE_W-1:0]  mag,
  output logic [fcm_pkg::Q_W-1:0]       q
);

  logic [32:0] p1;
  logic [32:0] p2;
  logic [31:0] p3;
  logic [15:0] g1;
  logic [15:0] g2;
  logic [fcm_pkg::RAMP_W-1:0]   rout_d;
  logic [fcm_pkg::SAMPLE_W-1:0] mag_d1;
  logic [fcm_pkg::SAMPLE_W-1:0] mag_d2;

  assign p1 = {17'b0, clip_gain} * {16'b0, rin};
  assign p2 = {17'b0, g1} * {16'b0, rout_d};
  assign p3 = {16'b0, mag_d2} * {16'b0, g2};

  always_ff @(posedge clk) begin
    g1     <= p1[31:16];
    rout_d <= rout;
    mag_d1 <= mag;
    g2     <= p2[31:16];
    mag_d2 <= mag_d1;
    q      <= p3[30:14];
  end

endmodule

// ===== rtl/fcm_buffer.sv =====
// fcm_buffer: sample buffer memory with post-reset clearing pass,
// read-modify-write with write forwarding, saturation and result register. Uses fcm_pkg.
module fcm_buffer #(
  parameter int BUFFER_SAMPLES = fcm_pkg::BUFFER_SAMPLES_DEF,
  parameter int ADDR_W         = $clog2(BUFFER_SAMPLES)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ADDR_W-1:0]                   rd_addr,
  input  fcm_pkg::item_ctl_t                  wr_ctl,
  input  logic [ADDR_W-1:0]                   wr_addr,
  input  logic [fcm_pkg::Q_W-1:0]             q,
  output logic                                busy,
  output logic                                done,
  output logic signed [fcm_pkg::SAMPLE_W-1:0] read_sample,
  output logic                                dropped
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_SAMPLES - 1);

  fcm_pkg::fcm_state_t state, state_next;

  logic [fcm_pkg::SAMPLE_W-1:0] mem [0:BUFFER_SAMPLES-1];
  logic [fcm_pkg::SAMPLE_W-1:0] rdata;
  logic [ADDR_W-1:0]            clr_cnt;
  logic                         fw_valid;
  logic [ADDR_W-1:0]            fw_addr;
  logic [fcm_pkg::SAMPLE_W-1:0] fw_data;

  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_wa;
  logic [fcm_pkg::SAMPLE_W-1:0] mem_wd;
  logic                         item_we;
  logic [fcm_pkg::SAMPLE_W-1:0] entry;
  logic signed [fcm_pkg::SUM_W-1:0] sum_ext;
  logic signed [fcm_pkg::SUM_W-1:0] sum;
  logic [fcm_pkg::SUM_W-1:0]    q_ext;
  logic signed [fcm_pkg::SAMPLE_W-1:0] sat;
  logic signed [fcm_pkg::SAMPLE_W-1:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    case (state)
      fcm_pkg::ST_CLEAR: begin
        busy = 1'b1;
        if (clr_cnt == LAST_ADDR) begin
          state_next = fcm_pkg::ST_RUN;
        end
      end
      fcm_pkg::ST_RUN: begin
        busy = 1'b0;
      end
      default: begin
        state_next = fcm_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // previous write is not yet visible to the read issued in the same cycle
  assign entry = (fw_valid && fw_addr == wr_addr) ? fw_data : rdata;

  assign sum_ext = {{(fcm_pkg::SUM_W - fcm_pkg::SAMPLE_W){entry[fcm_pkg::SAMPLE_W-1]}}, entry};
  assign q_ext   = {{(fcm_pkg::SUM_W - fcm_pkg::Q_W){1'b0}}, q};
  assign sum     = wr_ctl.neg ? sum_ext - signed'(q_ext) : sum_ext + signed'(q_ext);

  always_comb begin
    if (sum > fcm_pkg::SUM_W'(fcm_pkg::SAMPLE_MAX)) begin
      sat = fcm_pkg::SAMPLE_MAX;
    end else if (sum < fcm_pkg::SUM_W'(fcm_pkg::SAMPLE_MIN)) begin
      sat = fcm_pkg::SAMPLE_MIN;
    end else begin
      sat = sum[fcm_pkg::SAMPLE_W-1:0];
    end
  end

  assign item_we = wr_ctl.valid && !wr_ctl.drop;

  always_comb begin
    if (busy) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
      mem_wd = '0;
    end else begin
      mem_we = item_we;
      mem_wa = wr_addr;
      mem_wd = wr_ctl.is_read ? '0 : sat;
    end
  end

  assign result = wr_ctl.is_read ? signed'(entry) : sat;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || busy) begin
      fw_valid <= 1'b0;
    end else if (item_we) begin
      fw_valid <= 1'b1;
    end
    if (item_we) begin
      fw_addr <= wr_addr;
      fw_data <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= wr_ctl.valid;
    end
    read_sample <= wr_ctl.drop ? '0 : result;
    dropped     <= wr_ctl.drop;
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    wr_ctl.valid |=> done)
    else $error("item at write stage produced no result strobe");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_ctl.valid)
    else $error("item reached the buffer during the clearing pass");

  a_dropped_zero: assert property (@(posedge clk) disable iff (rst)
    (done && dropped) |-> (read_sample == '0))
    else $error("dropped result carries a nonzero sample");

  a_forward_after_write: assert property (@(posedge clk) disable iff (rst)
    (item_we && !busy) |=> (fw_valid && fw_addr == $past(wr_addr)))
    else $error("forwarding register missed a buffer write");
`endif

endmodule

// ===== rtl/faded_clip_mixer_unit.sv =====
// faded_clip_mixer_unit: top level of the faded clip mixer; configuration
// registers, address and drop checks, item pipeline. Uses fcm_pkg, fcm_ramp_div,
// fcm_gain_mul and fcm_buffer.

// The unit takes one transfer per clock whenever busy is low and returns exactly one
// result per transfer, in order: done is high for one cycle with read_sample and
// dropped. The receiver cannot stall; every strobe must be taken. The rate is set by
// the buffer memory, which sees one read and one write per cycle; the fade ramps come
// from two 16-stage divider pipelines (one quotient bit per stage) followed by three
// registered multiplies, so the pipeline holds up to 20 items. After reset, busy stays
// high while the buffer is swept to zero; configuration writes are taken during that
// pass. Write configuration only while no transfer is in flight.
module faded_clip_mixer_unit #(
  parameter int BUFFER_SAMPLES = fcm_pkg::BUFFER_SAMPLES_DEF,
  parameter int MAX_CHANNELS   = fcm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [fcm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fcm_pkg::CFG_DATA_W-1:0]        cfg_data,
  // item transfer
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  req_type,
  input  logic [fcm_pkg::FRAME_W-1:0]           frame_index,
  input  logic                                  channel,
  input  logic signed [fcm_pkg::SAMPLE_W-1:0]   source_sample,
  // result transfer
  output logic                                  done,
  output logic signed [fcm_pkg::SAMPLE_W-1:0]   read_sample,
  output logic                                  dropped
);

  localparam int ADDR_W  = $clog2(BUFFER_SAMPLES);
  localparam int GAIN_AT = fcm_pkg::DIV_LAT;                    // ramps ready
  localparam int LAST    = fcm_pkg::DIV_LAT + fcm_pkg::MUL_LAT; // write stage

  typedef struct packed {
    logic                         valid;
    logic                         is_read;
    logic                         drop;
    logic                         neg;
    logic [fcm_pkg::SAMPLE_W-1:0] mag;
    logic [ADDR_W-1:0]            addr;
  } sb_t;

  // configuration registers
  logic [fcm_pkg::GAIN_W-1:0]  clip_gain;
  logic [fcm_pkg::FRAME_W-1:0] fade_in_frames;
  logic [fcm_pkg::FRAME_W-1:0] fade_out_frames;
  logic [fcm_pkg::FRAME_W-1:0] clip_frames;
  logic [fcm_pkg::DEST_W-1:0]  dest_start_frame;
  logic [fcm_pkg::CHCNT_W-1:0] channel_count;

  // input register
  logic                                s0_valid;
  logic                                s0_req;
  logic [fcm_pkg::FRAME_W-1:0]         s0_frame;
  logic                                s0_ch;
  logic signed [fcm_pkg::SAMPLE_W-1:0] s0_sample;

  // front-stage decode
  logic [fcm_pkg::CHCNT_W-1:0]     cc;
  logic [fcm_pkg::FRAME_W:0]       base;
  logic [fcm_pkg::FRAME_W+2:0]     scaled;
  logic [fcm_pkg::ADDR_CALC_W-1:0] addr_full;
  logic                            drop;
  logic [fcm_pkg::FRAME_W-1:0]     d_out;
  logic                            in_full;
  logic                            out_full;
  sb_t                             sb0;
  sb_t                             sb [1:LAST];

  logic [fcm_pkg::RAMP_W-1:0] rin;
  logic [fcm_pkg::RAMP_W-1:0] rout;
  logic [fcm_pkg::Q_W-1:0]    q;
  fcm_pkg::item_ctl_t         wr_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_gain        <= fcm_pkg::CLIP_GAIN_RST;
      fade_in_frames   <= '0;
      fade_out_frames  <= '0;
      clip_frames      <= '0;
      dest_start_frame <= '0;
      channel_count    <= fcm_pkg::CHANNEL_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fcm_pkg::REG_CLIP_GAIN:     clip_gain        <= cfg_data[fcm_pkg::GAIN_W-1:0];
        fcm_pkg::REG_FADE_IN:       fade_in_frames   <= cfg_data[fcm_pkg::FRAME_W-1:0];
        fcm_pkg::REG_FADE_OUT:      fade_out_frames  <= cfg_data[fcm_pkg::FRAME_W-1:0];
        fcm_pkg::REG_CLIP_FRAMES:   clip_frames      <= cfg_data[fcm_pkg::FRAME_W-1:0];
        fcm_pkg::REG_DEST_START:    dest_start_frame <= cfg_data[fcm_pkg::DEST_W-1:0];
        fcm_pkg::REG_CHANNEL_COUNT: channel_count    <= cfg_data[fcm_pkg::CHCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register; payload follows the ports, valid marks a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_req    <= req_type;
    s0_frame  <= frame_index;
    s0_ch     <= channel;
    s0_sample <= source_sample;
  end

  // effective channel count: zero counts as one, clamped to MAX_CHANNELS
  always_comb begin
    if (channel_count == '0) begin
      cc = fcm_pkg::CHCNT_W'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      cc = fcm_pkg::CHCNT_W'(MAX_CHANNELS);
    end else begin
      cc = channel_count;
    end
  end

  // read items address the buffer frame directly; mix items are offset by the
  // clip's start frame
  assign base = (s0_req == fcm_pkg::REQ_READ)
              ? {1'b0, s0_frame}
              : {1'b0, s0_frame} + {{(fcm_pkg::FRAME_W + 1 - fcm_pkg::DEST_W){1'b0}},
                                    dest_start_frame};
  assign scaled    = {2'b0, base} * {{(fcm_pkg::FRAME_W + 1){1'b0}}, cc};
  assign addr_full = {1'b0, scaled} + {{(fcm_pkg::ADDR_CALC_W - 1){1'b0}}, s0_ch};

  assign drop = ({1'b0, s0_ch} >= cc)
             || (addr_full >= fcm_pkg::ADDR_CALC_W'(BUFFER_SAMPLES))
             || ((s0_req == fcm_pkg::REQ_MIX) && (s0_frame >= clip_frames));

  // fade-out distance; only meaningful for frames inside the clip
  assign d_out    = clip_frames - s0_frame;
  assign in_full  = (fade_in_frames == '0) || (s0_frame >= fade_in_frames);
  assign out_full = (fade_out_frames == '0) || (d_out >= fade_out_frames);

  always_comb begin
    sb0.valid   = s0_valid;
    sb0.is_read = (s0_req == fcm_pkg::REQ_READ);
    sb0.drop    = drop;
    sb0.neg     = s0_sample[fcm_pkg::SAMPLE_W-1];
    sb0.mag     = s0_sample[fcm_pkg::SAMPLE_W-1] ? fcm_pkg::SAMPLE_W'(-s0_sample)
                                                 : s0_sample;
    sb0.addr    = drop ? '0 : addr_full[ADDR_W-1:0];
  end

  // sideband delay line kept in step with the ramp and gain pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAST; k++) begin
        sb[k] <= '0;
      end
    end else begin
      sb[1] <= sb0;
      for (int k = 2; k <= LAST; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  fcm_ramp_div u_fade_in (
    .clk  (clk),
    .num  (s0_frame),
    .den  (fade_in_frames),
    .full (in_full),
    .ramp (rin)
  );

  fcm_ramp_div u_fade_out (
    .clk  (clk),
    .num  (d_out),
    .den  (fade_out_frames),
    .full (out_full),
    .ramp (rout)
  );

  fcm_gain_mul u_gain (
    .clk       (clk),
    .clip_gain (clip_gain),
    .rin       (rin),
    .rout      (rout),
    .mag       (sb[GAIN_AT].mag),
    .q         (q)
  );

  always_comb begin
    wr_ctl.valid   = sb[LAST].valid;
    wr_ctl.is_read = sb[LAST].is_read;
    wr_ctl.drop    = sb[LAST].drop;
    wr_ctl.neg     = sb[LAST].neg;
  end

  // read issued one stage ahead of the write stage
  fcm_buffer #(
    .BUFFER_SAMPLES (BUFFER_SAMPLES),
    .ADDR_W         (ADDR_W)
  ) u_buffer (
    .clk         (clk),
    .rst         (rst),
    .rd_addr     (sb[LAST-1].addr),
    .wr_ctl      (wr_ctl),
    .wr_addr     (sb[LAST].addr),
    .q           (q),
    .busy        (busy),
    .done        (done),
    .read_sample (read_sample),
    .dropped     (dropped)
  );

endmodule
